// ----- src/adc_crb_pkg.sv -----
// shared constants of the converter register block
package adc_crb_pkg;

   localparam int REG_WORDS_DEF = 32;
   localparam int CHANNELS_DEF  = 10;

   // word_index is 5 bits, so no more than this many words can be reached
   localparam int WORD_SPAN = 32;
   localparam int PAD_BITS  = 12;
   localparam int PAD_SHIFT = 19;

   localparam logic [1:0] MODE_READ    = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_DEPOSIT = 2'd2;

   localparam logic [4:0]  CTRL_WORD  = 5'(32'h0C >> 2);
   localparam logic [31:0] DATA_MASK  = 32'h0000_FFFF;
   localparam logic [31:0] DONE_MASK  = 32'h0001_0000;
   localparam logic [31:0] START_MASK = 32'h0002_0000;

endpackage

// ----- src/adc_conversion_register_block_top.sv -----
// converter register block: register bank, sample store and bus read/write path
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   request | req_valid req_stall req_mode req_word_index        | in
//           | req_write_data req_sample_channel req_sample_value |
//   reply   | rsp_valid rsp_stall rsp_read_data                  | out
//   req_stall is an output and rsp_stall an input.
// one beat per cycle while the request side is not stalled: an accepted beat
// is held in the input register, then updates the bank or sample store and,
// for a bus read, loads the reply register.
// reset clears the bank and the sample store at once; nothing else to wait for.
// only a read held behind a stalled reply stalls the request side.
module adc_conversion_register_block_top #(
   parameter int REG_WORDS = adc_crb_pkg::REG_WORDS_DEF,
   parameter int CHANNELS  = adc_crb_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_write_data,
   input  logic [7:0]  req_sample_channel,
   input  logic [15:0] req_sample_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data
);

   localparam int BANK_DEPTH = (REG_WORDS < adc_crb_pkg::WORD_SPAN) ?
                               REG_WORDS : adc_crb_pkg::WORD_SPAN;
   localparam int IDX_W  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PICK_N = (CHANNELS < adc_crb_pkg::PAD_BITS) ?
                           CHANNELS : adc_crb_pkg::PAD_BITS;

   logic [31:0] bank_ff [BANK_DEPTH];
   logic [15:0] sample_ff [CHANNELS];

   logic        s1_valid_ff;
   logic [1:0]  s1_mode_ff;
   logic [4:0]  s1_idx_ff;
   logic [31:0] s1_data_ff;
   logic [7:0]  s1_ch_ff;
   logic [15:0] s1_val_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_data_ff;

   logic        s1_is_read;
   logic        out_free;
   logic        advance;
   logic        s1_load;
   logic        word_hit;
   logic        ch_hit;
   logic [31:0] bank_word;
   logic [adc_crb_pkg::PAD_BITS-1:0] pads;
   logic [CH_W-1:0] pick;
   logic        ctrl_start;
   logic [31:0] read_word;
   logic [31:0] write_word;

   assign s1_is_read = (s1_mode_ff == adc_crb_pkg::MODE_READ);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && (!s1_is_read || out_free);
   assign req_stall  = s1_valid_ff && !advance;
   assign s1_load    = req_valid && !req_stall;

   assign word_hit  = ({1'b0, s1_idx_ff} < 6'(BANK_DEPTH));
   assign ch_hit    = (s1_ch_ff < 8'(CHANNELS));
   assign bank_word = word_hit ? bank_ff[s1_idx_ff[IDX_W-1:0]] : '0;
   assign pads      = bank_word[adc_crb_pkg::PAD_SHIFT +: adc_crb_pkg::PAD_BITS];

   // lowest enabled pad among the ones that have a channel
   always_comb begin
      pick = '0;
      for (int i = PICK_N - 1; i >= 0; i--) begin
         if (pads[i]) begin
            pick = CH_W'(i);
         end
      end
   end

   assign ctrl_start = (s1_idx_ff == adc_crb_pkg::CTRL_WORD) &&
                       ((bank_word & adc_crb_pkg::START_MASK) != '0);
   assign read_word  = ctrl_start ?
                       ((bank_word & ~adc_crb_pkg::DATA_MASK) | adc_crb_pkg::DONE_MASK |
                        {16'b0, sample_ff[pick]}) : bank_word;
   assign write_word = (s1_idx_ff == adc_crb_pkg::CTRL_WORD) ?
                       (s1_data_ff & ~(adc_crb_pkg::DONE_MASK | adc_crb_pkg::DATA_MASK)) :
                       s1_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && s1_is_read) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load || advance) begin
            s1_valid_ff <= s1_load;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_mode_ff <= req_mode;
         s1_idx_ff  <= req_word_index;
         s1_data_ff <= req_write_data;
         s1_ch_ff   <= req_sample_channel;
         s1_val_ff  <= req_sample_value;
      end
      if (advance && s1_is_read) begin
         rsp_data_ff <= read_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANK_DEPTH; i++) begin
            bank_ff[i] <= '0;
         end
      end else if (advance && s1_mode_ff == adc_crb_pkg::MODE_WRITE && word_hit) begin
         bank_ff[s1_idx_ff[IDX_W-1:0]] <= write_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sample_ff[i] <= '0;
         end
      end else if (advance && s1_mode_ff == adc_crb_pkg::MODE_DEPOSIT && ch_hit) begin
         sample_ff[s1_ch_ff[CH_W-1:0]] <= s1_val_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ----- src/adc_crb_checker.sv -----
// port-level checks of the converter register block, bound to the top level
module adc_crb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_data
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a waiting reply holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("reply dropped or changed while stalled");

   // a fresh reply comes from a read beat that went through the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_beat && req_mode == adc_crb_pkg::MODE_READ, 2))
      else $error("reply without a read beat");

   // writes, deposits and unused codes give no reply
   a_no_reply: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_mode != adc_crb_pkg::MODE_READ |-> ##2 !$rose(rsp_valid))
      else $error("reply from a beat that is not a read");

   // the request side only stalls behind a blocked reply
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with the reply side free");

endmodule

bind adc_conversion_register_block_top adc_crb_checker u_adc_crb_checker (.*);

// ----- tb/adc_crb_read_checker.sv -----
`timescale 1ns / 1ps
// checker: tracks the register bank and sample store, predicts every bus read reply
module adc_crb_read_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_write_data,
   input  logic [7:0]  req_sample_channel,
   input  logic [15:0] req_sample_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_read_data,
   output int          fail_count,
   output int          pending
);

   localparam int CH_W = (adc_crb_pkg::CHANNELS_DEF > 1) ?
                         $clog2(adc_crb_pkg::CHANNELS_DEF) : 1;

   logic [31:0] bank_model [adc_crb_pkg::WORD_SPAN];
   logic [15:0] sample_model [adc_crb_pkg::CHANNELS_DEF];
   logic [31:0] expected_read_words [$];

   // lowest enabled pad below the channel count, channel 0 when none
   function automatic int pad_channel(logic [31:0] ctrl);
      logic [adc_crb_pkg::PAD_BITS-1:0] pads;
      int chan;
      pads = ctrl[adc_crb_pkg::PAD_SHIFT +: adc_crb_pkg::PAD_BITS];
      chan = 0;
      for (int i = adc_crb_pkg::CHANNELS_DEF - 1; i >= 0; i--)
         if (i < adc_crb_pkg::PAD_BITS && pads[i]) chan = i;
      return chan;
   endfunction

   function automatic logic [31:0] bank_read(logic [4:0] idx);
      logic [31:0] word;
      word = '0;
      if (int'(idx) < adc_crb_pkg::REG_WORDS_DEF) begin
         word = bank_model[idx];
         if (idx == adc_crb_pkg::CTRL_WORD && (word & adc_crb_pkg::START_MASK) != '0) begin
            word = word | adc_crb_pkg::DONE_MASK;
            word = (word & ~adc_crb_pkg::DATA_MASK) | 32'(sample_model[pad_channel(word)]);
         end
      end
      return word;
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         for (int i = 0; i < adc_crb_pkg::WORD_SPAN; i++) bank_model[i] = '0;
         for (int i = 0; i < adc_crb_pkg::CHANNELS_DEF; i++) sample_model[i] = '0;
         expected_read_words.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_read_words.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected reply beat: read_data %h with no read pending",
                           rsp_read_data);
               fail_count = fail_count + 1;
            end else begin
               want = expected_read_words.pop_front();
               if (rsp_read_data !== want) begin
                  if (fail_count < 10)
                     $display("read_data mismatch: expected %h actual %h", want,
                              rsp_read_data);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_mode)
               adc_crb_pkg::MODE_READ: begin
                  expected_read_words.push_back(bank_read(req_word_index));
               end
               adc_crb_pkg::MODE_WRITE: begin
                  if (int'(req_word_index) < adc_crb_pkg::REG_WORDS_DEF) begin
                     // done and data bits of the control word belong to the converter
                     if (req_word_index == adc_crb_pkg::CTRL_WORD)
                        bank_model[req_word_index] = req_write_data &
                           ~(adc_crb_pkg::DONE_MASK | adc_crb_pkg::DATA_MASK);
                     else
                        bank_model[req_word_index] = req_write_data;
                  end
               end
               adc_crb_pkg::MODE_DEPOSIT: begin
                  if (int'(req_sample_channel) < adc_crb_pkg::CHANNELS_DEF)
                     sample_model[req_sample_channel[CH_W-1:0]] = req_sample_value;
               end
               default: ;
            endcase
         end
         pending <= expected_read_words.size();
      end
   end

endmodule

// ----- tb/tb_adc_conversion_register_block_top.sv -----
`timescale 1ns / 1ps
// testbench top: drives request beats and reply stalls, reports the verdict
module tb_adc_conversion_register_block_top;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 1130;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = adc_crb_pkg::MODE_READ;
   logic [4:0]  req_word_index = '0;
   logic [31:0] req_write_data = '0;
   logic [7:0]  req_sample_channel = '0;
   logic [15:0] req_sample_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;

   bit steady = 1'b0;
   int cycles = 0;
   int fail_count;
   int pending;

   adc_conversion_register_block_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_word_index     (req_word_index),
      .req_write_data     (req_write_data),
      .req_sample_channel (req_sample_channel),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data)
   );

   adc_crb_read_checker read_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_word_index     (req_word_index),
      .req_write_data     (req_write_data),
      .req_sample_channel (req_sample_channel),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_adc_conversion_register_block_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !steady && ($urandom_range(99) < 20);
   end

   task automatic issue_beat(input logic [1:0] mode, input logic [4:0] idx,
                             input logic [31:0] data, input logic [7:0] ch,
                             input logic [15:0] val);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_mode           <= mode;
      req_word_index     <= idx;
      req_write_data     <= data;
      req_sample_channel <= ch;
      req_sample_value   <= val;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mixed beat types; control word writes get pad masks and mostly start set
   task automatic random_beat();
      logic [1:0]  mode;
      logic [4:0]  idx;
      logic [31:0] data;
      logic [7:0]  ch;
      logic [15:0] val;
      logic [11:0] pads;
      int pick;
      pick = $urandom_range(99);
      data = $urandom;
      ch   = 8'($urandom);
      val  = 16'($urandom);
      idx  = ($urandom_range(99) < 40) ? adc_crb_pkg::CTRL_WORD : 5'($urandom_range(31));
      if (pick < 40)
         mode = adc_crb_pkg::MODE_READ;
      else if (pick < 70)
         mode = adc_crb_pkg::MODE_WRITE;
      else if (pick < 95)
         mode = adc_crb_pkg::MODE_DEPOSIT;
      else
         mode = MODE_UNUSED;
      if (mode == adc_crb_pkg::MODE_DEPOSIT && $urandom_range(99) < 80)
         ch = 8'($urandom_range(adc_crb_pkg::CHANNELS_DEF + 1));
      if (mode == adc_crb_pkg::MODE_WRITE && idx == adc_crb_pkg::CTRL_WORD) begin
         case ($urandom_range(3))
            0: pads = '0;
            1: pads = 12'(1) << $urandom_range(adc_crb_pkg::PAD_BITS - 1);
            2: pads = 12'($urandom);
            default: pads = {2'($urandom), 10'd0};
         endcase
         data[adc_crb_pkg::PAD_SHIFT +: adc_crb_pkg::PAD_BITS] = pads;
         if ($urandom_range(3) != 0)
            data = data | adc_crb_pkg::START_MASK;
         else
            data = data & ~adc_crb_pkg::START_MASK;
      end
      issue_beat(mode, idx, data, ch, val);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue_beat(adc_crb_pkg::MODE_READ, 5'd0, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_READ, adc_crb_pkg::CTRL_WORD, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_WRITE, 5'd31, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      issue_beat(adc_crb_pkg::MODE_READ, 5'd31, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_WRITE, 5'd0, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_DEPOSIT, 5'd0, 32'h0, 8'd0, 16'hFFFF);
      issue_beat(adc_crb_pkg::MODE_DEPOSIT, 5'd0, 32'h0,
                 8'(adc_crb_pkg::CHANNELS_DEF - 1), 16'hA5C3);
      // channel out of range, both just past the end and at the top
      issue_beat(adc_crb_pkg::MODE_DEPOSIT, 5'd0, 32'h0,
                 8'(adc_crb_pkg::CHANNELS_DEF), 16'h1234);
      issue_beat(adc_crb_pkg::MODE_DEPOSIT, 5'd0, 32'h0, 8'hFF, 16'h0);
      issue_beat(adc_crb_pkg::MODE_WRITE, adc_crb_pkg::CTRL_WORD, 32'hFFFF_FFFF, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_READ, adc_crb_pkg::CTRL_WORD, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_WRITE, adc_crb_pkg::CTRL_WORD,
                 (32'h1 << (adc_crb_pkg::PAD_SHIFT + 9)) | adc_crb_pkg::START_MASK,
                 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_READ, adc_crb_pkg::CTRL_WORD, 32'h0, 8'd0, 16'h0);
      // only pads above the channel count enabled
      issue_beat(adc_crb_pkg::MODE_WRITE, adc_crb_pkg::CTRL_WORD,
                 (32'h3 << (adc_crb_pkg::PAD_SHIFT + 10)) | adc_crb_pkg::START_MASK,
                 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_READ, adc_crb_pkg::CTRL_WORD, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_WRITE, adc_crb_pkg::CTRL_WORD,
                 32'hFFFF_FFFF & ~adc_crb_pkg::START_MASK, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_READ, adc_crb_pkg::CTRL_WORD, 32'h0, 8'd0, 16'h0);
      issue_beat(MODE_UNUSED, adc_crb_pkg::CTRL_WORD, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      issue_beat(adc_crb_pkg::MODE_READ, 5'd0, 32'h0, 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_DEPOSIT, 5'd0, 32'h0, 8'd5, 16'h5555);
      issue_beat(adc_crb_pkg::MODE_WRITE, adc_crb_pkg::CTRL_WORD,
                 (32'h1 << (adc_crb_pkg::PAD_SHIFT + 5)) | adc_crb_pkg::START_MASK,
                 8'd0, 16'h0);
      issue_beat(adc_crb_pkg::MODE_READ, adc_crb_pkg::CTRL_WORD, 32'h0, 8'd0, 16'h0);
      hold_until_drained();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         steady = (n >= 400 && n < 600);
         if (n == 800) hold_until_drained();
         random_beat();
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_adc_conversion_register_block_top passed");
      else
         $display("tb_adc_conversion_register_block_top failed");
      $finish;
   end

endmodule

// ----- adc_conversion_register_block_top.f -----
src/adc_crb_pkg.sv
src/adc_conversion_register_block_top.sv
src/adc_crb_checker.sv
tb/adc_crb_read_checker.sv
tb/tb_adc_conversion_register_block_top.sv
